@@ design/multichannel_strike_peak_detector_defines.svh @@
// ----------------------------------------------------------------------------
// multichannel_strike_peak_detector_defines
// assertion macros for the strike peak detector, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_STRIKE_PEAK_DETECTOR_DEFINES_SVH
`define MULTICHANNEL_STRIKE_PEAK_DETECTOR_DEFINES_SVH

`ifndef SYNTH
`define MSPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MSPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSPD_ASSERT_IMP(lbl, ante, cons)
`define MSPD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ design/mspd_pkg.sv @@
// ----------------------------------------------------------------------------
// mspd_pkg
// shared constants and types of the strike peak detector
// ----------------------------------------------------------------------------
package mspd_pkg;

  localparam int CHANNELS = 4;
  localparam int IN_CH    = 4;
  localparam int LANES    = (CHANNELS < IN_CH) ? CHANNELS : IN_CH;

  localparam int SAMPLE_W = 10;
  localparam int PEAK_W   = 10;
  localparam int CH_W     = 2;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 10;
  localparam int WIN_W    = 16;
  localparam int CFG_W    = 16;

  localparam logic [SAMPLE_W:0] MID_RAIL = 11'd512;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 10'd80;
  localparam logic [WIN_W-1:0] WINDOW_RESET    = 16'd20;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW    = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  typedef struct packed {
    logic              done;
    logic [PEAK_W-1:0] peak;
  } lane_fin_t;

  typedef struct packed {
    logic              valid;
    logic [CH_W-1:0]   channel;
    logic [PEAK_W-1:0] peak;
  } result_t;

endpackage

@@ design/multichannel_strike_peak_detector.sv @@
// ----------------------------------------------------------------------------
// multichannel_strike_peak_detector
// threshold triggered peak hold over four converter channels with poll
//
//   channel  handshake            payload
//   in       in_valid/in_ready    op, four samples, now_ms
//   out      out_valid/out_ready  event_valid, event_channel, event_peak
//   cfg      cfg_we               cfg_index, cfg_wdata
//
// one item per cycle; each item gives one result in the cycle after acceptance
// all lanes and the slot update in the accept cycle, result sits in an
// output register; in_ready is low only while that register is full and
// out_ready is low. synchronous reset clears strikes, slot and valid registers
// ----------------------------------------------------------------------------
`include "multichannel_strike_peak_detector_defines.svh"

module multichannel_strike_peak_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [mspd_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [mspd_pkg::SAMPLE_W-1:0]     in_sample_ch0,
  input  logic [mspd_pkg::SAMPLE_W-1:0]     in_sample_ch1,
  input  logic [mspd_pkg::SAMPLE_W-1:0]     in_sample_ch2,
  input  logic [mspd_pkg::SAMPLE_W-1:0]     in_sample_ch3,
  input  logic [mspd_pkg::TIME_W-1:0]       in_now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_event_valid,
  output logic [mspd_pkg::CH_W-1:0]         out_event_channel,
  output logic [mspd_pkg::PEAK_W-1:0]       out_event_peak
);

  logic [mspd_pkg::THR_W-1:0]  thr_r;
  logic [mspd_pkg::WIN_W-1:0]  win_r;

  logic                        in_acc;
  logic                        sample_en;
  logic                        poll_en;
  logic                        pending;

  logic [mspd_pkg::SAMPLE_W-1:0]             samples [mspd_pkg::IN_CH];
  mspd_pkg::lane_fin_t [mspd_pkg::LANES-1:0] fin;
  mspd_pkg::result_t                         res;

  logic                        out_valid_r;
  mspd_pkg::result_t           out_r;

  assign samples[0] = in_sample_ch0;
  assign samples[1] = in_sample_ch1;
  assign samples[2] = in_sample_ch2;
  assign samples[3] = in_sample_ch3;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign sample_en = in_acc && (in_op == mspd_pkg::OP_SAMPLE);
  assign poll_en   = in_acc && (in_op == mspd_pkg::OP_POLL);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= mspd_pkg::THRESHOLD_RESET;
      win_r <= mspd_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mspd_pkg::REG_THRESHOLD: thr_r <= cfg_wdata[mspd_pkg::THR_W-1:0];
        mspd_pkg::REG_WINDOW:    win_r <= cfg_wdata[mspd_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < mspd_pkg::LANES; g++) begin : g_lane
    mspd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .sample_en (sample_en),
      .sample    (samples[g]),
      .now_ms    (in_now_ms),
      .threshold (thr_r),
      .window    (win_r),
      .fin       (fin[g])
    );
  end

  mspd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .poll_en   (poll_en),
    .op        (in_op),
    .fin       (fin),
    .res       (res),
    .pending   (pending)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (in_acc) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_valid   = out_r.valid;
  assign out_event_channel = out_r.channel;
  assign out_event_peak    = out_r.peak;

  `MSPD_ASSERT_NXT(a_empty_poll, poll_en && !pending, out_valid && !out_event_valid)
  `MSPD_ASSERT_NXT(a_sample_quiet, sample_en, out_valid && !out_event_valid)
  `MSPD_ASSERT_IMP(a_zero_fields, out_valid && !out_event_valid, (out_event_channel == '0) && (out_event_peak == '0))
  `MSPD_ASSERT_IMP(a_peak_range, out_valid && out_event_valid, out_event_peak <= 10'd512)

endmodule

@@ design/mspd_lane.sv @@
// ----------------------------------------------------------------------------
// mspd_lane
// per-channel strike tracker: trigger, peak hold and window expiry
// ----------------------------------------------------------------------------
module mspd_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            sample_en,
  input  logic [mspd_pkg::SAMPLE_W-1:0]   sample,
  input  logic [mspd_pkg::TIME_W-1:0]     now_ms,
  input  logic [mspd_pkg::THR_W-1:0]      threshold,
  input  logic [mspd_pkg::WIN_W-1:0]      window,
  output mspd_pkg::lane_fin_t             fin
);

  logic                           active_r, active_nxt;
  logic [mspd_pkg::PEAK_W-1:0]    peak_r, peak_nxt;
  logic [mspd_pkg::TIME_W-1:0]    start_r, start_nxt;

  logic [mspd_pkg::SAMPLE_W:0]    s_ext;
  logic [mspd_pkg::SAMPLE_W:0]    dev_wide;
  logic [mspd_pkg::PEAK_W-1:0]    dev;
  logic [mspd_pkg::PEAK_W-1:0]    pk;
  logic [mspd_pkg::TIME_W-1:0]    elapsed;
  logic                           expired;

  assign s_ext    = {1'b0, sample};
  assign dev_wide = (s_ext >= mspd_pkg::MID_RAIL) ? (s_ext - mspd_pkg::MID_RAIL)
                                                  : (mspd_pkg::MID_RAIL - s_ext);
  assign dev      = dev_wide[mspd_pkg::PEAK_W-1:0];
  assign pk       = (dev > peak_r) ? dev : peak_r;
  assign elapsed  = now_ms - start_r;
  assign expired  = elapsed >= {{(mspd_pkg::TIME_W-mspd_pkg::WIN_W){1'b0}}, window};

  always_comb begin
    active_nxt = active_r;
    peak_nxt   = peak_r;
    start_nxt  = start_r;
    fin.done   = 1'b0;
    fin.peak   = pk;
    if (sample_en) begin
      if (!active_r) begin
        if ({1'b0, dev} >= {1'b0, threshold}) begin
          active_nxt = 1'b1;
          peak_nxt   = dev;
          start_nxt  = now_ms;
        end
      end else if (expired) begin
        fin.done   = 1'b1;
        active_nxt = 1'b0;
        peak_nxt   = '0;
      end else begin
        peak_nxt = pk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      peak_r   <= '0;
      start_r  <= '0;
    end else begin
      active_r <= active_nxt;
      peak_r   <= peak_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

@@ design/mspd_merge.sv @@
// ----------------------------------------------------------------------------
// mspd_merge
// lowest-channel pick of finished strikes into the pending slot, poll result
// ----------------------------------------------------------------------------
module mspd_merge (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      sample_en,
  input  logic                                      poll_en,
  input  logic                                      op,
  input  mspd_pkg::lane_fin_t [mspd_pkg::LANES-1:0] fin,
  output mspd_pkg::result_t                         res,
  output logic                                      pending
);

  logic                         pend_r, pend_nxt;
  logic [mspd_pkg::CH_W-1:0]    ch_r, ch_nxt;
  logic [mspd_pkg::PEAK_W-1:0]  pk_r, pk_nxt;

  logic                         win_found;
  logic [mspd_pkg::CH_W-1:0]    win_ch;
  logic [mspd_pkg::PEAK_W-1:0]  win_peak;

  always_comb begin
    win_found = 1'b0;
    win_ch    = '0;
    win_peak  = '0;
    for (int i = 0; i < mspd_pkg::LANES; i++) begin
      if (fin[i].done && !win_found) begin
        win_found = 1'b1;
        win_ch    = mspd_pkg::CH_W'(i);
        win_peak  = fin[i].peak;
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    ch_nxt   = ch_r;
    pk_nxt   = pk_r;
    if (sample_en && !pend_r && win_found) begin
      pend_nxt = 1'b1;
      ch_nxt   = win_ch;
      pk_nxt   = win_peak;
    end else if (poll_en) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    res.valid   = (op == mspd_pkg::OP_POLL) && pend_r;
    res.channel = res.valid ? ch_r : '0;
    res.peak    = res.valid ? pk_r : '0;
  end

  assign pending = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      ch_r   <= '0;
      pk_r   <= '0;
    end else begin
      pend_r <= pend_nxt;
      ch_r   <= ch_nxt;
      pk_r   <= pk_nxt;
    end
  end

endmodule

@@ verif/strike_event_checker.sv @@
// ----------------------------------------------------------------------------
// strike_event_checker
// watches the item and result channels of the strike peak detector, keeps
// its own copy of the per-channel strike state and the event slot, and
// compares every result with the oldest predicted event, field by field
// ----------------------------------------------------------------------------
module strike_event_checker
  import mspd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_op,
  input  logic [SAMPLE_W-1:0] in_sample_ch0,
  input  logic [SAMPLE_W-1:0] in_sample_ch1,
  input  logic [SAMPLE_W-1:0] in_sample_ch2,
  input  logic [SAMPLE_W-1:0] in_sample_ch3,
  input  logic [TIME_W-1:0]   in_now_ms,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_event_valid,
  input  logic [CH_W-1:0]     out_event_channel,
  input  logic [PEAK_W-1:0]   out_event_peak,
  output int                  fail_count,
  output int                  events_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [THR_W-1:0]  trig_level;
  logic [WIN_W-1:0]  hold_ms;
  logic              strike_on  [CHANNELS];
  logic [PEAK_W-1:0] peak_held  [CHANNELS];
  logic [TIME_W-1:0] started_at [CHANNELS];
  logic              slot_full;
  logic [CH_W-1:0]   slot_ch;
  logic [PEAK_W-1:0] slot_peak;
  result_t           events_due [$];

  logic [IN_CH-1:0][SAMPLE_W-1:0] lane_in;
  assign lane_in = {in_sample_ch3, in_sample_ch2, in_sample_ch1, in_sample_ch0};

  function automatic logic [PEAK_W-1:0] offset_from_mid(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W:0] wide;
    wide = {1'b0, s};
    if (wide >= MID_RAIL) wide = wide - MID_RAIL;
    else wide = MID_RAIL - wide;
    return wide[PEAK_W-1:0];
  endfunction

  function automatic result_t strike_step(input logic op,
                                          input logic [IN_CH-1:0][SAMPLE_W-1:0] smp,
                                          input logic [TIME_W-1:0] now);
    result_t           res;
    logic [PEAK_W-1:0] dev;
    logic [TIME_W-1:0] elapsed;
    res = '0;
    if (op == OP_SAMPLE) begin
      for (int c = 0; c < LANES; c++) begin
        dev = offset_from_mid(smp[c]);
        if (!strike_on[c]) begin
          if (dev >= trig_level) begin
            strike_on[c]  = 1'b1;
            peak_held[c]  = dev;
            started_at[c] = now;
          end
        end else begin
          if (dev > peak_held[c]) peak_held[c] = dev;
          elapsed = now - started_at[c];
          if (elapsed >= TIME_W'(hold_ms)) begin
            if (!slot_full) begin
              slot_full = 1'b1;
              slot_ch   = c[CH_W-1:0];
              slot_peak = peak_held[c];
            end
            strike_on[c] = 1'b0;
            peak_held[c] = '0;
          end
        end
      end
    end else if (slot_full) begin
      res.valid   = 1'b1;
      res.channel = slot_ch;
      res.peak    = slot_peak;
      slot_full   = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      trig_level = THRESHOLD_RESET;
      hold_ms    = WINDOW_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        strike_on[c]  = 1'b0;
        peak_held[c]  = '0;
        started_at[c] = '0;
      end
      slot_full = 1'b0;
      slot_ch   = '0;
      slot_peak = '0;
      events_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (events_due.size() == 0) begin
          fail_count++;
          $error("result with no item waiting: valid %0d channel %0d peak %0d",
                 out_event_valid, out_event_channel, out_event_peak);
        end else begin
          want = events_due.pop_front();
          if (out_event_valid !== want.valid) begin
            fail_count++;
            $error("event_valid: expected %0d, got %0d", want.valid, out_event_valid);
          end
          if (out_event_channel !== want.channel) begin
            fail_count++;
            $error("event_channel: expected %0d, got %0d", want.channel, out_event_channel);
          end
          if (out_event_peak !== want.peak) begin
            fail_count++;
            $error("event_peak: expected %0d, got %0d", want.peak, out_event_peak);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: trig_level = cfg_wdata[THR_W-1:0];
          REG_WINDOW:    hold_ms    = cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        events_due.push_back(strike_step(in_op, lane_in, in_now_ms));
    end
    events_owed = events_due.size();
  end

endmodule

@@ verif/multichannel_strike_peak_detector_test.sv @@
// ----------------------------------------------------------------------------
// multichannel_strike_peak_detector_test
// drives sample and poll items into the strike peak detector: a directed
// strike sequence first, then random phases over several threshold and
// window settings with sender gaps and receiver stalls; the checker beside
// the block predicts and compares every event
// ----------------------------------------------------------------------------
module multichannel_strike_peak_detector_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mspd_pkg::*;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                cfg_we        = 1'b0;
  logic                cfg_index     = REG_THRESHOLD;
  logic [CFG_W-1:0]    cfg_wdata     = '0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic                in_op         = OP_SAMPLE;
  logic [SAMPLE_W-1:0] in_sample_ch0 = '0;
  logic [SAMPLE_W-1:0] in_sample_ch1 = '0;
  logic [SAMPLE_W-1:0] in_sample_ch2 = '0;
  logic [SAMPLE_W-1:0] in_sample_ch3 = '0;
  logic [TIME_W-1:0]   in_now_ms     = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic                out_event_valid;
  logic [CH_W-1:0]     out_event_channel;
  logic [PEAK_W-1:0]   out_event_peak;

  int                  fail_count;
  int                  events_owed;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  logic [TIME_W-1:0]   clock_ms       = 32'd100;

  multichannel_strike_peak_detector dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_sample_ch0     (in_sample_ch0),
    .in_sample_ch1     (in_sample_ch1),
    .in_sample_ch2     (in_sample_ch2),
    .in_sample_ch3     (in_sample_ch3),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_valid   (out_event_valid),
    .out_event_channel (out_event_channel),
    .out_event_peak    (out_event_peak)
  );

  strike_event_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_sample_ch0     (in_sample_ch0),
    .in_sample_ch1     (in_sample_ch1),
    .in_sample_ch2     (in_sample_ch2),
    .in_sample_ch3     (in_sample_ch3),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_valid   (out_event_valid),
    .out_event_channel (out_event_channel),
    .out_event_peak    (out_event_peak),
    .fail_count        (fail_count),
    .events_owed       (events_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
  end

  task automatic send_item(input logic op,
                           input logic [SAMPLE_W-1:0] s0, s1, s2, s3,
                           input logic [TIME_W-1:0] now);
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_sample_ch0 <= s0;
    in_sample_ch1 <= s1;
    in_sample_ch2 <= s2;
    in_sample_ch3 <= s3;
    in_now_ms     <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (events_owed != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(input logic [THR_W-1:0] thr, input logic [WIN_W-1:0] win);
    cfg_we    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_wdata <= CFG_W'(thr);
    @(posedge clk);
    cfg_index <= REG_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    int          v;
    roll = $urandom_range(99, 0);
    if (roll < 55) v = 512 + $urandom_range(50, 0) - 25;
    else if (roll < 90) v = $urandom_range(1023, 0);
    else if (roll < 94) v = 0;
    else if (roll < 98) v = 1023;
    else v = 512;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic advance_clock();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 85) clock_ms = clock_ms + $urandom_range(4, 0);
    else if (roll < 95) clock_ms = clock_ms + $urandom_range(40, 5);
    else if (roll < 99) clock_ms = clock_ms + $urandom_range(70000, 0);
    else clock_ms = $urandom;
  endtask

  task automatic run_phase(input logic [THR_W-1:0] thr, input logic [WIN_W-1:0] win,
                           input int unsigned idle, input int unsigned stall,
                           input int n_items);
    wait_quiet();
    set_config(thr, win);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(149, 0) == 0) wait_quiet();
      if ($urandom_range(3, 0) == 0) begin
        send_item(OP_POLL, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                  SAMPLE_W'($urandom), SAMPLE_W'($urandom), $urandom);
      end else begin
        advance_clock();
        send_item(OP_SAMPLE, pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                  clock_ms);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: threshold 80, window 20
    send_item(OP_POLL,   10'd0,   10'd0,    10'd0,   10'd0,    32'd0);
    send_item(OP_SAMPLE, 10'd0,   10'd1023, 10'd512, 10'd432,  32'd100);
    send_item(OP_SAMPLE, 10'd512, 10'd512,  10'd433, 10'd431,  32'd110);
    send_item(OP_SAMPLE, 10'd512, 10'd1000, 10'd512, 10'd631,  32'd119);
    send_item(OP_SAMPLE, 10'd512, 10'd512,  10'd512, 10'd512,  32'd120);
    send_item(OP_POLL,   10'd1023, 10'd1023, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
    send_item(OP_POLL,   10'd0,   10'd0,    10'd0,   10'd0,    32'd0);
    send_item(OP_SAMPLE, 10'd512, 10'd512,  10'd100, 10'd512,  32'd121);
    send_item(OP_SAMPLE, 10'd512, 10'd512,  10'd512, 10'd512,  32'd141);
    send_item(OP_POLL,   10'd0,   10'd0,    10'd0,   10'd0,    32'd0);
    send_item(OP_SAMPLE, 10'd512, 10'd512,  10'd512, 10'd1023, 32'd200);
    send_item(OP_SAMPLE, 10'd511, 10'd513,  10'd512, 10'd512,  32'd220);
    send_item(OP_POLL,   10'd0,   10'd0,    10'd0,   10'd0,    32'd0);
    // timestamp wrap inside a strike window
    send_item(OP_SAMPLE, 10'd0,   10'd512,  10'd512, 10'd512,  32'hFFFF_FFF8);
    send_item(OP_SAMPLE, 10'd512, 10'd512,  10'd512, 10'd512,  32'd12);
    send_item(OP_POLL,   10'd0,   10'd0,    10'd0,   10'd0,    32'd0);

    clock_ms = 32'd1000;
    run_phase(10'd80,   16'd20,    0,  0,  220);
    run_phase(10'd0,    16'd0,     81, 0,  220);
    run_phase(10'd1023, 16'd65535, 0,  81, 220);
    clock_ms = 32'hFFFF_FF00;
    run_phase(10'd200,  16'd3,     22, 22, 220);
    run_phase(10'd512,  16'd1,     0,  0,  220);
    run_phase(THR_W'($urandom_range(300, 20)), WIN_W'($urandom_range(50, 0)),
              81, 0, 220);
    run_phase(10'd100,  16'd10,    0,  81, 220);
    run_phase(10'd40,   16'd0,     22, 22, 220);
    run_phase(THR_W'($urandom_range(1023, 0)), WIN_W'($urandom),
              0, 0, 220);

    wait_quiet();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/mspd_pkg.sv
design/mspd_lane.sv
design/mspd_merge.sv
design/multichannel_strike_peak_detector.sv
verif/strike_event_checker.sv
verif/multichannel_strike_peak_detector_test.sv
